### hdl/block_transfer_byte_ring_fifo_macros.svh
// Assertion macros for the block transfer byte ring FIFO.
`ifndef BLOCK_TRANSFER_BYTE_RING_FIFO_MACROS_SVH
`define BLOCK_TRANSFER_BYTE_RING_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bfr_pkg.sv
// Shared types and constants for the block transfer byte ring FIFO.
`timescale 1ns / 1ps

package bfr_pkg;

    // Fixed field widths
    localparam int SW  = 9;   // ring size, fill level
    localparam int LW  = 7;   // block length
    localparam int BW  = 8;   // data byte
    localparam int KW  = 2;   // item kind
    localparam int STW = 2;   // result status

    // Item kinds
    localparam logic [KW-1:0] K_PUT  = 2'd0;
    localparam logic [KW-1:0] K_POP  = 2'd1;
    localparam logic [KW-1:0] K_PEEK = 2'd2;

    // Result status codes
    localparam logic [STW-1:0] ST_OK    = 2'd0;
    localparam logic [STW-1:0] ST_FULL  = 2'd1;
    localparam logic [STW-1:0] ST_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

### hdl/bfr_ring_mem.sv
// Byte ring storage: one write port, one registered read port.
`timescale 1ns / 1ps

module bfr_ring_mem
    import bfr_pkg::*;
#(
    parameter int CAP = 256,
    parameter int AW  = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [BW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [BW-1:0] o_rdata
);

    logic [BW-1:0] r_mem [CAP];
    logic [BW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bfr_idx_step.sv
// Shared ring index stepper: increment with wrap at the configured size.
`timescale 1ns / 1ps

module bfr_idx_step
    import bfr_pkg::*;
#(
    parameter int AW = 8
) (
    input  logic [AW-1:0] i_idx,
    input  logic [SW-1:0] i_size,
    output logic [AW-1:0] o_next
);

    logic [SW-1:0] inc;

    // Wrap to zero once the incremented index reaches the ring size
    assign inc    = SW'(i_idx) + SW'(1);
    assign o_next = (inc >= i_size) ? '0 : inc[AW-1:0];

endmodule

### hdl/block_transfer_byte_ring_fifo.sv
// A put item's result (last byte only) is registered and appears in the cycle after the item is taken.
// Pop/peek: the request is checked first, then one byte is read per cycle while the output slot
// is free, set by the single read port of the ring store and the shared index stepper.
// A rejected pop/peek gives one empty result; an unknown kind gives none. Output stalls hold the sequencer.
// Reset (synchronous, active low): ring empty, no put block open, size = min(DEPTH, 256).
// The ring store is not cleared; only committed bytes are ever read.
`timescale 1ns / 1ps

module block_transfer_byte_ring_fifo
    import bfr_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_BLOCK = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input items
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [KW-1:0]  i_kind,
    input  logic [LW-1:0]  i_block_length,
    input  logic [BW-1:0]  i_put_byte,
    // result items
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [BW-1:0]  o_out_byte,
    output logic           o_last,
    output logic [STW-1:0] o_status,
    output logic [SW-1:0]  o_fill_level,
    // configuration
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [SW-1:0]  i_cfg_buffer_size
);

    `include "block_transfer_byte_ring_fifo_macros.svh"

    localparam int CAP = (DEPTH < 256) ? DEPTH : 256;
    localparam int AW  = $clog2(CAP);

    t_state         r_state,     n_state;
    logic [SW-1:0]  r_size,      n_size;
    logic [AW-1:0]  r_rd_idx,    n_rd_idx;
    logic [AW-1:0]  r_wr_idx,    n_wr_idx;
    logic [SW-1:0]  r_count,     n_count;
    logic [AW-1:0]  r_stage,     n_stage;
    logic [LW-1:0]  r_put_left,  n_put_left;
    logic           r_put_ok,    n_put_ok;
    logic [LW-1:0]  r_put_len,   n_put_len;
    logic [AW-1:0]  r_idx,       n_idx;
    logic [LW-1:0]  r_rd_left,   n_rd_left;
    logic           r_is_pop,    n_is_pop;
    logic           r_out_valid, n_out_valid;
    logic           r_out_last,  n_out_last;
    logic [STW-1:0] r_out_st,    n_out_st;
    logic [SW-1:0]  r_out_fill,  n_out_fill;
    logic           r_out_data,  n_out_data;

    logic           cfg_fire, in_fire, load_ok;
    logic [SW-1:0]  cfg_size;
    logic [LW-1:0]  len_c;
    logic           put_open, put_fits, blk_ok;
    logic [LW-1:0]  blk_len, left_n;
    logic [AW-1:0]  stage_cur;
    logic [AW-1:0]  step_in, step_out;
    logic [SW-1:0]  count_add;
    logic           mem_we, mem_re;
    logic [BW-1:0]  mem_rdata;

    // Handshakes
    assign load_ok     = !r_out_valid || i_out_ready;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && load_ok && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // Configured size, clamped to 1..CAP
    always_comb begin
        cfg_size = i_cfg_buffer_size;
        if (i_cfg_buffer_size == '0) begin
            cfg_size = SW'(1);
        end else if (i_cfg_buffer_size > SW'(CAP)) begin
            cfg_size = SW'(CAP);
        end
    end

    // Requested length, clamped to 1..MAX_BLOCK
    always_comb begin
        len_c = i_block_length;
        if (i_block_length == '0) begin
            len_c = LW'(1);
        end else if (i_block_length > LW'(MAX_BLOCK)) begin
            len_c = LW'(MAX_BLOCK);
        end
    end

    // Put block bookkeeping: the opening byte decides length and acceptance
    assign put_open  = (r_put_left != '0);
    assign put_fits  = (SW'(len_c) <= (r_size - r_count));
    assign blk_len   = put_open ? r_put_len : len_c;
    assign blk_ok    = put_open ? r_put_ok : put_fits;
    assign stage_cur = put_open ? r_stage : r_wr_idx;
    assign left_n    = (put_open ? r_put_left : len_c) - LW'(1);
    assign count_add = r_count + SW'(blk_len);

    // One index stepper, shared by the staging and the read sequences
    assign step_in = (r_state == S_READ) ? r_idx : stage_cur;

    bfr_idx_step #(
        .AW (AW)
    ) u_step (
        .i_idx  (step_in),
        .i_size (r_size),
        .o_next (step_out)
    );

    bfr_ring_mem #(
        .CAP (CAP),
        .AW  (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (stage_cur),
        .i_wdata (i_put_byte),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_count     = r_count;
        n_stage     = r_stage;
        n_put_left  = r_put_left;
        n_put_ok    = r_put_ok;
        n_put_len   = r_put_len;
        n_idx       = r_idx;
        n_rd_left   = r_rd_left;
        n_is_pop    = r_is_pop;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_st    = r_out_st;
        n_out_fill  = r_out_fill;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    // new size empties the ring and drops any open block
                    n_size     = cfg_size;
                    n_rd_idx   = '0;
                    n_wr_idx   = '0;
                    n_count    = '0;
                    n_stage    = '0;
                    n_put_left = '0;
                    n_put_ok   = 1'b0;
                    n_put_len  = '0;
                end else if (in_fire) begin
                    if (i_kind == K_PUT) begin
                        // stage the byte; commit at the last byte of the block
                        n_put_len  = blk_len;
                        n_put_ok   = blk_ok;
                        n_put_left = left_n;
                        if (blk_ok) begin
                            mem_we  = 1'b1;
                            n_stage = step_out;
                        end
                        if (left_n == '0) begin
                            n_put_ok    = 1'b0;
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_out_data  = 1'b0;
                            if (blk_ok) begin
                                n_wr_idx   = step_out;
                                n_count    = count_add;
                                n_out_st   = ST_OK;
                                n_out_fill = count_add;
                            end else begin
                                n_out_st   = ST_FULL;
                                n_out_fill = r_count;
                            end
                        end
                    end else if (i_kind inside {K_POP, K_PEEK}) begin
                        if (SW'(len_c) > r_count) begin
                            // not enough bytes stored: one empty result
                            n_out_valid = 1'b1;
                            n_out_last  = 1'b1;
                            n_out_data  = 1'b0;
                            n_out_st    = ST_EMPTY;
                            n_out_fill  = r_count;
                        end else begin
                            n_is_pop  = (i_kind == K_POP);
                            n_idx     = r_rd_idx;
                            n_rd_left = len_c;
                            if (i_kind == K_POP) begin
                                n_count = r_count - SW'(len_c);
                            end
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                // one byte per cycle while the output slot frees up
                if (load_ok) begin
                    mem_re      = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_last  = (r_rd_left == LW'(1));
                    n_out_data  = 1'b1;
                    n_out_st    = ST_OK;
                    n_out_fill  = r_count;
                    n_idx       = step_out;
                    n_rd_left   = r_rd_left - LW'(1);
                    if (r_rd_left == LW'(1)) begin
                        if (r_is_pop) begin
                            n_rd_idx = step_out;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SW'(CAP);
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_count     <= '0;
            r_stage     <= '0;
            r_put_left  <= '0;
            r_put_ok    <= 1'b0;
            r_put_len   <= '0;
            r_idx       <= '0;
            r_rd_left   <= '0;
            r_is_pop    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_count     <= n_count;
            r_stage     <= n_stage;
            r_put_left  <= n_put_left;
            r_put_ok    <= n_put_ok;
            r_put_len   <= n_put_len;
            r_idx       <= n_idx;
            r_rd_left   <= n_rd_left;
            r_is_pop    <= n_is_pop;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_last <= n_out_last;
        r_out_st   <= n_out_st;
        r_out_fill <= n_out_fill;
        r_out_data <= n_out_data;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_data ? mem_rdata : '0;
    assign o_last       = r_out_last;
    assign o_status     = r_out_st;
    assign o_fill_level = r_out_fill;

    // Checks
    `BFR_ASSERT_NOW(a_count_in_size, i_clk, i_rst_n, 1'b1, r_count <= r_size, "fill above ring size")
    `BFR_ASSERT_NOW(a_read_idx_range, i_clk, i_rst_n, r_state == S_READ, SW'(r_idx) < r_size, "read index outside ring")
    `BFR_ASSERT_NOW(a_status_last, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, o_last && o_out_byte == '0, "status result not a lone last item")
    `BFR_ASSERT_NEXT(a_read_no_accept, i_clk, i_rst_n, in_fire && n_state == S_READ, !o_in_ready, "item taken during a read sequence")

endmodule
